// File: rtl/fbd_pkg.sv
// fbd_pkg: shared types, codes and defaults for the page framebuffer draw block
// no dependencies; used by the channel interfaces, the top level and the bench
package fbd_pkg;

  localparam int MAX_WIDTH_DEF = 128;
  localparam int MAX_PAGES_DEF = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'b1;

  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;

  localparam logic [7:0] BYTE_LIT  = 8'hFF;
  localparam logic [7:0] BYTE_DARK = 8'h00;
  localparam logic [3:0] BLIT_MAX  = 4'd8;

  typedef enum logic [2:0] {
    FN_FILL  = 3'd0,
    FN_PIXEL = 3'd1,
    FN_RECT  = 3'd2,
    FN_BLIT  = 3'd3,
    FN_READ  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PIX_RD,
    S_PIX_WR,
    S_FILL,
    S_READ,
    S_RDWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [6:0] end_x;
    logic [5:0] end_y;
    logic       pixel_on;
    logic       filled;
    logic [7:0] bitmap;
    logic [3:0] bit_count;
    logic [9:0] address;
    logic       mark_clean;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_dirty;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

endpackage

// File: rtl/fbd_if.sv
// fbd channel interfaces: command, result and configuration write channels
// depends on fbd_pkg for the item types
interface fbd_in_if;
  import fbd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface fbd_out_if;
  import fbd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface fbd_cfg_if;
  import fbd_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: rtl/fbd_ram.sv
// fbd_ram: generic single write port, single read port ram with registered read
// no dependencies
module fbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mono_page_framebuffer_draw.sv
// mono_page_framebuffer_draw: 1 bpp page organised frame store with drawing operations
// depends on fbd_pkg, fbd_if (channels) and fbd_ram (frame store)
//
//   channel  dir  carries
//   cmd      in   func, coordinates, colour, bitmap, read address
//   rsp      out  read_data, is_dirty
//   cfg      in   panel_width / panel_height writes
//
// set pixel: one read-modify-write of a store byte, skipped when clipped; read: a registered
// store read, skipped beyond the store; blit: a read-modify-write per unclipped bit; an empty
// blit, a rectangle ending before its start or an unused func goes straight to the result; a
// rectangle walks its bounding box, each written pixel a read-modify-write via one port pair
// fill: writes each byte in use in turn; the shared multiplier forms byte index and fill size
// after reset a clearing pass darkens all MAX_WIDTH*MAX_PAGES bytes before cmd is ready
// a finished item waits in the rsp register until rsp takes it; cfg is always ready
module mono_page_framebuffer_draw #(
  parameter int MAX_WIDTH = fbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PAGES = fbd_pkg::MAX_PAGES_DEF
) (
  input logic    clk,
  input logic    rst,
  fbd_cfg_if.sink  cfg,
  fbd_in_if.sink   cmd,
  fbd_out_if.source rsp
);
  import fbd_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_PAGES * 8 + 1);
  localparam int PB    = 5;
  localparam int PW    = WB + PB;

  state_t state, state_next;

  logic [7:0] pw, pw_next;
  logic [6:0] ph, ph_next;
  logic dirty, dirty_next;
  logic out_valid, out_valid_next;
  out_item_t out_q, out_q_next;

  logic [2:0] op, op_next;
  logic [6:0] x0, x0_next, x1, x1_next, cur_x, cur_x_next;
  logic [6:0] y0, y0_next, y1, y1_next, cur_y, cur_y_next;
  logic on_q, on_q_next, filled_q, filled_q_next, clean_q, clean_q_next;
  logic [7:0] bitmap_q, bitmap_q_next;
  logic [9:0] addr_q, addr_q_next;
  logic [AW-1:0] idx_q, idx_q_next;
  logic [2:0] bit_q, bit_q_next;
  logic col_q, col_q_next;
  logic [CW-1:0] n_q, n_q_next, cnt, cnt_next;
  logic [7:0] rd_q, rd_q_next;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;

  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [4:0] pages_raw;
  logic [PB-1:0] pages_eff, mul_b;
  logic [PW-1:0] prod;
  logic [AW-1:0] pix_idx;
  logic in_panel, on_edge, last_pix, pix_col;
  logic [2:0] bsel;
  logic [3:0] cnt_eff;
  logic [7:0] mask;

  assign w_eff = (32'(pw) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(pw);
  assign h_eff = (32'(ph) > MAX_PAGES * 8) ? HB'(MAX_PAGES * 8) : HB'(ph);
  assign pages_raw = 5'((8'(ph) + 8'd7) >> 3);
  assign pages_eff = (32'(pages_raw) > MAX_PAGES) ? PB'(MAX_PAGES) : PB'(pages_raw);

  // shared multiplier: fill size when idle, page offset while walking pixels
  assign mul_b = (state == S_IDLE) ? pages_eff : PB'(cur_y[6:3]);
  assign prod = PW'(w_eff) * PW'(mul_b);
  assign pix_idx = AW'(prod + PW'(cur_x));

  assign in_panel = (32'(cur_x) < 32'(w_eff)) && (32'(cur_y) < 32'(h_eff));
  assign on_edge = filled_q || (cur_x == x0) || (cur_x == x1) || (cur_y == y0)
                   || (cur_y == y1);
  assign last_pix = (cur_y == y1) && (cur_x == x1);
  assign bsel = 3'(cur_y - y0);
  assign pix_col = (op == FN_BLIT) ? (bitmap_q[bsel] ? on_q : !on_q) : on_q;
  assign cnt_eff = (cmd.item.bit_count > BLIT_MAX) ? BLIT_MAX : cmd.item.bit_count;
  assign mask = 8'(8'd1 << bit_q);

  fbd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.item = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pw        <= WIDTH_RESET;
      ph        <= HEIGHT_RESET;
      dirty     <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      pw        <= pw_next;
      ph        <= ph_next;
      dirty     <= dirty_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
    end
    out_q    <= out_q_next;
    op       <= op_next;
    x0       <= x0_next;
    x1       <= x1_next;
    y0       <= y0_next;
    y1       <= y1_next;
    cur_x    <= cur_x_next;
    cur_y    <= cur_y_next;
    on_q     <= on_q_next;
    filled_q <= filled_q_next;
    clean_q  <= clean_q_next;
    bitmap_q <= bitmap_q_next;
    addr_q   <= addr_q_next;
    idx_q    <= idx_q_next;
    bit_q    <= bit_q_next;
    col_q    <= col_q_next;
    n_q      <= n_q_next;
    rd_q     <= rd_q_next;
  end

  always_comb begin
    state_next     = state;
    pw_next        = pw;
    ph_next        = ph;
    dirty_next     = dirty;
    out_valid_next = out_valid && !rsp.ready;
    out_q_next     = out_q;
    op_next        = op;
    x0_next        = x0;
    x1_next        = x1;
    y0_next        = y0;
    y1_next        = y1;
    cur_x_next     = cur_x;
    cur_y_next     = cur_y;
    on_q_next      = on_q;
    filled_q_next  = filled_q;
    clean_q_next   = clean_q;
    bitmap_q_next  = bitmap_q;
    addr_q_next    = addr_q;
    idx_q_next     = idx_q;
    bit_q_next     = bit_q;
    col_q_next     = col_q;
    n_q_next       = n_q;
    cnt_next       = cnt;
    rd_q_next      = rd_q;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    if (cfg.valid) begin
      case (cfg.item.index)
        REG_PANEL_WIDTH:  pw_next = cfg.item.data;
        REG_PANEL_HEIGHT: ph_next = 7'(cfg.item.data);
        default: ;
      endcase
    end

    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
        ram_wdata = BYTE_DARK;
        if (cnt == CW'(DEPTH - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd.valid) begin
          op_next       = cmd.item.func;
          on_q_next     = cmd.item.pixel_on;
          filled_q_next = 1'b1;
          clean_q_next  = cmd.item.mark_clean;
          bitmap_q_next = cmd.item.bitmap;
          addr_q_next   = cmd.item.address;
          rd_q_next     = '0;
          x0_next       = cmd.item.pos_x;
          x1_next       = cmd.item.pos_x;
          y0_next       = 7'(cmd.item.pos_y);
          y1_next       = 7'(cmd.item.pos_y);
          cur_x_next    = cmd.item.pos_x;
          cur_y_next    = 7'(cmd.item.pos_y);
          case (cmd.item.func)
            FN_FILL: begin
              dirty_next = 1'b1;
              n_q_next   = CW'(prod);
              cnt_next   = '0;
              state_next = (prod == '0) ? S_DONE : S_FILL;
            end
            FN_PIXEL: begin
              dirty_next = 1'b1;
              state_next = S_PIX_RD;
            end
            FN_RECT: begin
              filled_q_next = cmd.item.filled;
              x1_next       = cmd.item.end_x;
              y1_next       = 7'(cmd.item.end_y);
              if (cmd.item.end_x >= cmd.item.pos_x && cmd.item.end_y >= cmd.item.pos_y) begin
                dirty_next = 1'b1;
                state_next = S_PIX_RD;
              end else begin
                state_next = S_DONE;
              end
            end
            FN_BLIT: begin
              dirty_next = 1'b1;
              y1_next    = 7'(7'(cmd.item.pos_y) + 7'(cnt_eff) - 7'd1);
              state_next = (cnt_eff == '0) ? S_DONE : S_PIX_RD;
            end
            FN_READ: begin
              state_next = (32'(cmd.item.address) < DEPTH) ? S_READ : S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_PIX_RD, S_PIX_WR: begin
        if (state == S_PIX_WR || !(in_panel && on_edge)) begin
          if (state == S_PIX_WR) begin
            ram_we    = 1'b1;
            ram_waddr = idx_q;
            ram_wdata = col_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
          end
          state_next = S_PIX_RD;
          if (last_pix) begin
            state_next = S_DONE;
          end else if (cur_y == y1) begin
            cur_x_next = cur_x + 1'b1;
            cur_y_next = y0;
          end else begin
            cur_y_next = cur_y + 1'b1;
          end
        end else begin
          ram_raddr  = pix_idx;
          idx_q_next = pix_idx;
          bit_q_next = cur_y[2:0];
          col_q_next = pix_col;
          state_next = S_PIX_WR;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
        ram_wdata = on_q ? BYTE_LIT : BYTE_DARK;
        cnt_next  = cnt + 1'b1;
        if (cnt + 1'b1 == n_q) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        ram_raddr  = AW'(addr_q);
        state_next = S_RDWAIT;
      end
      S_RDWAIT: begin
        rd_q_next  = ram_rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next       = 1'b1;
          out_q_next.read_data = rd_q;
          out_q_next.is_dirty  = dirty;
          if (op == FN_READ && clean_q) begin
            dirty_next = 1'b0;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // no item taken while the clearing pass runs
  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.ready)
    else $error("cmd ready during clearing pass");

  // only clear, fill and pixel write states touch the store
  a_store_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_FILL || state == S_PIX_WR))
    else $error("store written from unexpected state");

  // the dirty mark falls only as a clean read hands over its item
  a_dirty_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(dirty) |-> ($past(state == S_DONE) && $past(op == FN_READ) && $past(clean_q)))
    else $error("dirty mark cleared outside clean read");
`endif

endmodule

// File: bench/fbd_bench_if.sv
// bench side note: channel interfaces come from rtl/fbd_if.sv
// this file holds the bench's shared frame store image type and its size only
// depends on fbd_pkg
package fbd_bench_pkg;
  import fbd_pkg::*;
  localparam int STORE_BYTES = MAX_WIDTH_DEF * MAX_PAGES_DEF;
  typedef logic [7:0] frame_img_t [STORE_BYTES];
endpackage

// File: bench/mono_page_framebuffer_draw_test.sv
// mono_page_framebuffer_draw_test: drives drawing commands and register writes into the
// frame store block and checks every result against an in-bench model of the store
// depends on fbd_pkg, fbd_bench_pkg, fbd_if and the block itself
module mono_page_framebuffer_draw_test;
  import fbd_pkg::*;
  import fbd_bench_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   failed = 1'b0;

  fbd_cfg_if cfg ();
  fbd_in_if  cmd ();
  fbd_out_if rsp ();

  mono_page_framebuffer_draw dut (.clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .rsp(rsp));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  frame_img_t  shadow_store;
  bit          shadow_dirty;
  int unsigned shadow_width;
  int unsigned shadow_height;
  out_item_t   expected_q[$];
  bit          rx_stall_on;
  int          stall_phase;
  int          idle_cycles;

  function automatic int unsigned used_width();
    return shadow_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : shadow_width;
  endfunction

  function automatic int unsigned used_pages();
    int unsigned p;
    p = (shadow_height + 7) / 8;
    return p > MAX_PAGES_DEF ? MAX_PAGES_DEF : p;
  endfunction

  function automatic void plot(int unsigned x, int unsigned y, bit on);
    int unsigned w, h, idx;
    w = used_width();
    h = shadow_height > MAX_PAGES_DEF * 8 ? MAX_PAGES_DEF * 8 : shadow_height;
    if (x >= w || y >= h) return;
    idx = x + (y / 8) * w;
    if (idx >= STORE_BYTES) return;
    shadow_store[idx][y % 8] = on;
  endfunction

  function automatic out_item_t draw_and_predict(in_item_t it);
    out_item_t   res;
    int unsigned n, cnt;
    res.read_data = BYTE_DARK;
    case (it.func)
      FN_FILL: begin
        n = used_width() * used_pages();
        if (n > STORE_BYTES) n = STORE_BYTES;
        for (int i = 0; i < n; i++) shadow_store[i] = it.pixel_on ? BYTE_LIT : BYTE_DARK;
        shadow_dirty = 1'b1;
      end
      FN_PIXEL: begin
        plot(it.pos_x, it.pos_y, it.pixel_on);
        shadow_dirty = 1'b1;
      end
      FN_RECT: begin
        if (it.end_x >= it.pos_x && it.end_y >= it.pos_y) begin
          for (int i = it.pos_x; i <= it.end_x; i++)
            for (int j = it.pos_y; j <= it.end_y; j++)
              if (it.filled || i == it.pos_x || i == it.end_x || j == it.pos_y
                  || j == it.end_y)
                plot(i, j, it.pixel_on);
          shadow_dirty = 1'b1;
        end
      end
      FN_BLIT: begin
        cnt = it.bit_count > BLIT_MAX ? BLIT_MAX : it.bit_count;
        for (int i = 0; i < cnt; i++)
          plot(it.pos_x, it.pos_y + i, it.bitmap[i] ? it.pixel_on : !it.pixel_on);
        shadow_dirty = 1'b1;
      end
      FN_READ: begin
        if (it.address < STORE_BYTES) res.read_data = shadow_store[it.address];
      end
      default: ;
    endcase
    res.is_dirty = shadow_dirty;
    if (it.func == FN_READ && it.mark_clean) shadow_dirty = 1'b0;
    return res;
  endfunction

  task automatic send_item(in_item_t it);
    cmd.item  <= it;
    cmd.valid <= 1'b1;
    do @(posedge clk); while (!cmd.ready);
    expected_q.push_back(draw_and_predict(it));
    if ($urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    drain();
    cfg.item.index <= idx;
    cfg.item.data  <= val;
    cfg.valid      <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_PANEL_WIDTH) shadow_width = val;
    else shadow_height = val[6:0];
  endtask

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned ex, ey;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    case ($urandom_range(0, 19))
      0: it.func = FN_FILL;
      1, 2, 3, 4, 5: it.func = FN_PIXEL;
      6, 7, 8: it.func = FN_RECT;
      9, 10, 11, 12: it.func = FN_BLIT;
      13, 14, 15, 16, 17, 18: it.func = FN_READ;
      default: it.func = func_t'($urandom_range(5, 7));
    endcase
    if (it.func == FN_RECT && $urandom_range(0, 3) != 0) begin
      ex = it.pos_x + $urandom_range(0, 12);
      ey = it.pos_y + $urandom_range(0, 8);
      it.end_x = ex > 127 ? 7'd127 : 7'(ex);
      it.end_y = ey > 63 ? 6'd63 : 6'(ey);
    end
    if (it.func == FN_READ && $urandom_range(0, 3) != 0) it.address = 10'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t op(func_t f, int px, int py, int ex, int ey, bit on,
                                  bit fl, int bmp, int cnt, int adr, bit cl);
    in_item_t it;
    it.func = f; it.pos_x = 7'(px); it.pos_y = 6'(py); it.end_x = 7'(ex); it.end_y = 6'(ey);
    it.pixel_on = on; it.filled = fl; it.bitmap = 8'(bmp); it.bit_count = 4'(cnt);
    it.address = 10'(adr); it.mark_clean = cl;
    return it;
  endfunction

  task automatic test_directed();
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(op(FN_FILL, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023, 1));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023, 0));
    send_item(op(FN_PIXEL, 127, 63, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023, 1));
    send_item(op(FN_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(op(FN_RECT, 10, 5, 3, 9, 1, 1, 0, 0, 0, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(op(FN_RECT, 9, 9, 3, 3, 1, 1, 0, 0, 0, 0));
    send_item(op(FN_RECT, 2, 3, 9, 12, 1, 0, 0, 0, 0, 0));
    send_item(op(FN_RECT, 120, 60, 127, 63, 1, 1, 0, 0, 0, 0));
    send_item(op(FN_RECT, 4, 4, 4, 4, 1, 0, 0, 0, 0, 0));
    send_item(op(FN_BLIT, 5, 60, 0, 0, 1, 0, 8'hA5, 8, 0, 0));
    send_item(op(FN_BLIT, 6, 3, 0, 0, 0, 0, 8'hFF, 15, 0, 0));
    send_item(op(FN_BLIT, 7, 0, 0, 0, 1, 0, 8'h00, 0, 0, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 901, 1));
    send_item(op(func_t'(3'd5), 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(op(func_t'(3'd7), 127, 63, 127, 63, 1, 1, 255, 15, 1023, 1));
    send_item(op(FN_PIXEL, 200 % 128, 10, 0, 0, 1, 0, 0, 0, 0, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 72, 1));
  endtask

  task automatic test_config_extremes();
    write_reg(REG_PANEL_WIDTH, 8'd1);
    write_reg(REG_PANEL_HEIGHT, 8'd1);
    send_item(op(FN_FILL, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_item(op(FN_PIXEL, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    write_reg(REG_PANEL_WIDTH, 8'd255);
    write_reg(REG_PANEL_HEIGHT, 8'd127);
    send_item(op(FN_PIXEL, 127, 63, 0, 0, 1, 0, 0, 0, 0, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023, 1));
    write_reg(REG_PANEL_WIDTH, 8'd0);
    write_reg(REG_PANEL_HEIGHT, 8'd0);
    send_item(op(FN_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(op(FN_BLIT, 0, 0, 0, 0, 1, 0, 8'hFF, 8, 0, 0));
    send_item(op(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023, 1));
  endtask

  task automatic test_random_sweep();
    int unsigned widths[4] = '{128, 37, 8, 200};
    int unsigned heights[4] = '{64, 21, 8, 100};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_PANEL_WIDTH, 8'(widths[ph]));
      write_reg(REG_PANEL_HEIGHT, 8'(heights[ph]));
      for (int k = 0; k < 125; k++) begin
        if (k == 60) drain();
        send_item(rand_item());
      end
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 < 20) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: read_data %0h", rsp.item.read_data);
        failed = 1'b1;
      end else begin
        want = expected_q.pop_front();
        if (rsp.item.read_data !== want.read_data) begin
          $error("read_data expected %0h actual %0h", want.read_data, rsp.item.read_data);
          failed = 1'b1;
        end
        if (rsp.item.is_dirty !== want.is_dirty) begin
          $error("is_dirty expected %0b actual %0b", want.is_dirty, rsp.item.is_dirty);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("mono_page_framebuffer_draw_test NOT OK");
      $finish;
    end
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.item = '0;
    cfg.valid = 1'b0;
    cfg.item = '0;
    rsp.ready = 1'b0;
    stall_phase = 0;
    idle_cycles = 0;
    shadow_store = '{default: 8'h00};
    shadow_dirty = 1'b0;
    shadow_width = WIDTH_RESET;
    shadow_height = HEIGHT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_random_sweep();
    drain();
    repeat (20) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("mono_page_framebuffer_draw_test OK");
    end else begin
      $display("mono_page_framebuffer_draw_test NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/fbd_pkg.sv
rtl/fbd_if.sv
rtl/fbd_ram.sv
rtl/mono_page_framebuffer_draw.sv
bench/fbd_bench_if.sv
bench/mono_page_framebuffer_draw_test.sv
